// ===== src/pwm_duty_to_register_writer_macros.svh =====
// Assertion helpers used by the top-level RTL.
`ifndef PWM_DUTY_TO_REGISTER_WRITER_MACROS_SVH
`define PWM_DUTY_TO_REGISTER_WRITER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define PDRW_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define PDRW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PDRW_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define PDRW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== src/pdrw_pkg.sv =====
package pdrw_pkg;

    localparam int unsigned COUNT_STEPS_DEF   = 4096;
    localparam int unsigned CHANNEL_COUNT_DEF = 16;

    localparam int unsigned VAL_W  = 31;
    localparam int unsigned CHAN_W = 4;

    // request kinds
    localparam logic [1:0] KIND_CONFIG  = 2'd0;
    localparam logic [1:0] KIND_ENABLE  = 2'd1;
    localparam logic [1:0] KIND_DISABLE = 2'd2;

    // enable state
    localparam logic [1:0] EN_OFF     = 2'd0;
    localparam logic [1:0] EN_ON      = 2'd1;
    localparam logic [1:0] EN_UNKNOWN = 2'd2;

    // write sequence shapes
    localparam logic [1:0] MODE_OFF  = 2'd0;
    localparam logic [1:0] MODE_FULL = 2'd1;
    localparam logic [1:0] MODE_EDGE = 2'd2;

    // device register offsets within a channel group
    localparam logic [6:0] ADDR_ON_L  = 7'h06;
    localparam logic [6:0] ADDR_ON_H  = 7'h07;
    localparam logic [6:0] ADDR_OFF_L = 7'h08;
    localparam logic [6:0] ADDR_OFF_H = 7'h09;
    localparam logic [7:0] FULL_FLAG  = 8'h10;

    typedef struct packed {
        logic [1:0]       kind;
        logic [VAL_W-1:0] duty;
        logic [VAL_W-1:0] period;
        logic             polarity;
    } req_t;

    typedef struct packed {
        logic [6:0] reg_address;
        logic [7:0] reg_data;
        logic       last;
    } wr_t;

    typedef struct packed {
        logic       go;
        logic [1:0] mode;
    } seq_start_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ===== src/pdrw_div.sv =====
// Restoring divider, one quotient bit per cycle. The caller guarantees the
// quotient fits in QW bits, so the upper dividend bits seed the remainder.
module pdrw_div #(
    parameter int unsigned QW = 13
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [pdrw_pkg::VAL_W+QW-1:0]        dividend,
    input  logic [pdrw_pkg::VAL_W-1:0]           divisor,
    output pdrw_pkg::div_stat_t                  stat,
    output logic [QW-1:0]                        quotient
);

    localparam int unsigned VW = pdrw_pkg::VAL_W;
    localparam int unsigned CW = $clog2(QW);

    logic [VW-1:0] rem_reg, rem_next;
    logic [VW-1:0] dvs_reg, dvs_next;
    logic [QW-1:0] lo_reg, lo_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;

    logic [VW+1:0] diff;
    logic          ge;

    always_comb
    begin
        diff = {1'b0, rem_reg, lo_reg[QW-1]} - {2'b00, dvs_reg};
        ge   = !diff[VW+1];
    end

    always_comb
    begin
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        lo_next   = lo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = dividend[VW+QW-1:QW];
            lo_next   = dividend[QW-1:0];
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[VW-1:0] : {rem_reg[VW-2:0], lo_reg[QW-1]};
            // dividend bits leave at the top, quotient bits enter at the bottom
            lo_next  = {lo_reg[QW-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(QW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        lo_reg  <= lo_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = lo_reg;

endmodule

// ===== src/pdrw_wr.sv =====
// Emits the register write sequence, one word per accepted output.
module pdrw_wr #(
    parameter int unsigned COUNT_STEPS   = pdrw_pkg::COUNT_STEPS_DEF,
    parameter int unsigned CHANNEL_COUNT = pdrw_pkg::CHANNEL_COUNT_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  pdrw_pkg::seq_start_t               start,
    input  logic [$clog2(COUNT_STEPS+1)-1:0]   count,
    input  logic [pdrw_pkg::CHAN_W-1:0]        channel,
    output logic                               wr_valid,
    input  logic                               wr_ready,
    output pdrw_pkg::wr_t                      wr,
    output logic                               done
);

    localparam int unsigned EW      = $clog2(COUNT_STEPS);
    localparam int unsigned PH_STEP = COUNT_STEPS / CHANNEL_COUNT;
    localparam int unsigned NCH     = 2 ** pdrw_pkg::CHAN_W;

    logic [EW-1:0] phase_tab [NCH];

    for (genvar i = 0; i < NCH; i++)
    begin : g_phase
        localparam int unsigned PH = (i * PH_STEP) % COUNT_STEPS;
        assign phase_tab[i] = EW'(PH);
    end

    logic [EW-1:0]   on_edge, off_edge;
    logic [EW:0]     edge_sum;
    logic [6:0]      grp;
    logic [15:0]     on16, off16;
    pdrw_pkg::wr_t   word;
    logic            load;

    logic [1:0]      mode_reg, mode_next;
    logic [EW-1:0]   on_reg, on_next;
    logic [EW-1:0]   off_reg, off_next;
    logic [1:0]      idx_reg, idx_next;
    logic            pend_reg, pend_next;
    logic            valid_reg, valid_next;
    pdrw_pkg::wr_t   wr_reg, wr_next;

    always_comb
    begin
        on_edge  = phase_tab[channel];
        edge_sum = (EW+1)'(on_edge) + (EW+1)'(count[EW-1:0]);
        // both terms below COUNT_STEPS: one subtract wraps it
        if (edge_sum >= (EW+1)'(COUNT_STEPS))
            off_edge = EW'(edge_sum - (EW+1)'(COUNT_STEPS));
        else
            off_edge = edge_sum[EW-1:0];
    end

    always_comb
    begin
        grp  = 7'({channel, 2'b00});
        on16 = 16'(on_reg);
        off16 = 16'(off_reg);
        word = '0;
        case (mode_reg)
            pdrw_pkg::MODE_OFF:
            begin
                word.reg_address = pdrw_pkg::ADDR_OFF_H + grp;
                word.reg_data    = pdrw_pkg::FULL_FLAG;
                word.last        = 1'b1;
            end
            pdrw_pkg::MODE_FULL:
            begin
                if (idx_reg == 2'd0)
                begin
                    word.reg_address = pdrw_pkg::ADDR_ON_H + grp;
                    word.reg_data    = pdrw_pkg::FULL_FLAG;
                    word.last        = 1'b0;
                end
                else
                begin
                    word.reg_address = pdrw_pkg::ADDR_OFF_H + grp;
                    word.reg_data    = 8'h00;
                    word.last        = 1'b1;
                end
            end
            pdrw_pkg::MODE_EDGE:
            begin
                // ON_L, ON_H, OFF_L, OFF_H are consecutive
                word.reg_address = pdrw_pkg::ADDR_ON_L + grp + 7'(idx_reg);
                case (idx_reg)
                    2'd0:    word.reg_data = on16[7:0];
                    2'd1:    word.reg_data = {4'h0, on16[11:8]};
                    2'd2:    word.reg_data = off16[7:0];
                    default: word.reg_data = {4'h0, off16[11:8]};
                endcase
                word.last = (idx_reg == 2'd3);
            end
            default:
            begin
                word.reg_address = pdrw_pkg::ADDR_OFF_H + grp;
                word.reg_data    = pdrw_pkg::FULL_FLAG;
                word.last        = 1'b1;
            end
        endcase
    end

    assign load = pend_reg && (!valid_reg || wr_ready);

    always_comb
    begin
        mode_next  = mode_reg;
        on_next    = on_reg;
        off_next   = off_reg;
        idx_next   = idx_reg;
        pend_next  = pend_reg;
        valid_next = valid_reg;
        wr_next    = wr_reg;
        if (start.go)
        begin
            mode_next = start.mode;
            on_next   = on_edge;
            off_next  = off_edge;
            idx_next  = 2'd0;
            pend_next = 1'b1;
        end
        else if (load)
        begin
            wr_next    = word;
            valid_next = 1'b1;
            idx_next   = idx_reg + 2'd1;
            pend_next  = !word.last;
        end
        else if (wr_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg  <= 1'b0;
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
            mode_reg  <= pdrw_pkg::MODE_OFF;
        end
        else
        begin
            pend_reg  <= pend_next;
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
            mode_reg  <= mode_next;
        end
    end

    always_ff @(posedge clk)
    begin
        on_reg  <= on_next;
        off_reg <= off_next;
        wr_reg  <= wr_next;
    end

    assign wr_valid = valid_reg;
    assign wr       = wr_reg;
    assign done     = valid_reg && wr_ready && wr_reg.last;

endmodule

// ===== src/pwm_duty_to_register_writer.sv =====
// PWM duty to register writer. Each request word (configure, enable,
// disable) is compared with the kept channel state; a request that changes
// nothing, or an enable/disable before the first configure, produces no
// writes. A change yields one, two or four register write words on the wr
// channel, the final one flagged last. A change that needs no division
// (disabled channel, period zero, duty at or past the period with polarity
// set, or past it with polarity clear) goes from PREP straight to SEND.
// When the on-count must be divided out, the request passes through PREP,
// MUL, DIV and SEND, and in DIV a bit-serial divider works out the
// clog2(COUNT_STEPS+1)-bit quotient (13 bits at 4096 steps). Write words
// wait while wr_ready is low. A new request is taken once the last write
// word has been accepted. The channel register is to be written only while
// no request is in flight.
`include "pwm_duty_to_register_writer_macros.svh"

module pwm_duty_to_register_writer #(
    parameter int unsigned COUNT_STEPS   = pdrw_pkg::COUNT_STEPS_DEF,
    parameter int unsigned CHANNEL_COUNT = pdrw_pkg::CHANNEL_COUNT_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [pdrw_pkg::CHAN_W-1:0]  cfg_data,
    input  logic                         req_valid,
    output logic                         req_ready,
    input  pdrw_pkg::req_t               req,
    output logic                         wr_valid,
    input  logic                         wr_ready,
    output pdrw_pkg::wr_t                wr
);

    localparam int unsigned VW = pdrw_pkg::VAL_W;
    localparam int unsigned QW = $clog2(COUNT_STEPS + 1);
    localparam int unsigned NW = VW + QW;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PREP = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_SEND = 3'd4;

    logic [2:0]                   state_reg, state_next;
    logic [pdrw_pkg::CHAN_W-1:0]  chan_reg, chan_next;
    logic [1:0]                   en_reg, en_next;
    logic [VW-1:0]                duty_reg, duty_next;
    logic [VW-1:0]                period_reg, period_next;
    logic                         pol_reg, pol_next;
    logic                         known_reg, known_next;
    logic [VW-1:0]                numer_reg, numer_next;

    logic                  accept;
    logic                  div_start;
    logic [NW-1:0]         dividend;
    pdrw_pkg::div_stat_t   div_st;
    logic [QW-1:0]         quotient;
    pdrw_pkg::seq_start_t  seq_start;
    logic [QW-1:0]         seq_count;
    logic                  seq_done;
    logic                  want_on;

    assign req_ready = (state_reg == ST_IDLE);
    assign accept    = req_valid && req_ready;
    assign chan_next = cfg_we ? cfg_data : chan_reg;
    assign dividend  = NW'(numer_reg) * NW'(COUNT_STEPS);
    assign want_on   = (req.kind == pdrw_pkg::KIND_ENABLE);

    always_comb
    begin
        state_next  = state_reg;
        en_next     = en_reg;
        duty_next   = duty_reg;
        period_next = period_reg;
        pol_next    = pol_reg;
        known_next  = known_reg;
        numer_next  = numer_reg;
        div_start   = 1'b0;
        seq_start   = '0;
        seq_count   = quotient;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req.kind == pdrw_pkg::KIND_CONFIG)
                    begin
                        if (!(known_reg && req.duty == duty_reg &&
                              req.period == period_reg && req.polarity == pol_reg))
                        begin
                            duty_next   = req.duty;
                            period_next = req.period;
                            pol_next    = req.polarity;
                            known_next  = 1'b1;
                            state_next  = ST_PREP;
                        end
                    end
                    else if (req.kind == pdrw_pkg::KIND_ENABLE ||
                             req.kind == pdrw_pkg::KIND_DISABLE)
                    begin
                        if (en_reg != (want_on ? pdrw_pkg::EN_ON : pdrw_pkg::EN_OFF))
                        begin
                            en_next = want_on ? pdrw_pkg::EN_ON : pdrw_pkg::EN_OFF;
                            if (known_reg)
                                state_next = ST_PREP;
                        end
                    end
                end
            end
            ST_PREP:
            begin
                // unknown enable state counts as enabled
                seq_start.go = 1'b1;
                state_next   = ST_SEND;
                if (en_reg == pdrw_pkg::EN_OFF)
                    seq_start.mode = pol_reg ? pdrw_pkg::MODE_OFF : pdrw_pkg::MODE_FULL;
                else if (period_reg == '0)
                    seq_start.mode = pdrw_pkg::MODE_OFF;
                else if (pol_reg && duty_reg >= period_reg)
                    seq_start.mode = pdrw_pkg::MODE_FULL;
                else if (!pol_reg && duty_reg > period_reg)
                    seq_start.mode = pdrw_pkg::MODE_OFF;
                else
                begin
                    seq_start.go = 1'b0;
                    numer_next   = pol_reg ? duty_reg : period_reg - duty_reg;
                    state_next   = ST_MUL;
                end
            end
            ST_MUL:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_st.done)
                begin
                    seq_start.go = 1'b1;
                    if (quotient == '0)
                        seq_start.mode = pdrw_pkg::MODE_OFF;
                    else if (quotient >= QW'(COUNT_STEPS))
                        seq_start.mode = pdrw_pkg::MODE_FULL;
                    else
                        seq_start.mode = pdrw_pkg::MODE_EDGE;
                    state_next = ST_SEND;
                end
            end
            ST_SEND:
            begin
                if (seq_done)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            chan_reg   <= '0;
            en_reg     <= pdrw_pkg::EN_UNKNOWN;
            duty_reg   <= '0;
            period_reg <= '0;
            pol_reg    <= 1'b0;
            known_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            chan_reg   <= chan_next;
            en_reg     <= en_next;
            duty_reg   <= duty_next;
            period_reg <= period_next;
            pol_reg    <= pol_next;
            known_reg  <= known_next;
        end
    end

    always_ff @(posedge clk)
    begin
        numer_reg <= numer_next;
    end

    pdrw_div #(
        .QW (QW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (period_reg),
        .stat     (div_st),
        .quotient (quotient)
    );

    pdrw_wr #(
        .COUNT_STEPS   (COUNT_STEPS),
        .CHANNEL_COUNT (CHANNEL_COUNT)
    ) u_wr (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (seq_start),
        .count    (seq_count),
        .channel  (chan_reg),
        .wr_valid (wr_valid),
        .wr_ready (wr_ready),
        .wr       (wr),
        .done     (seq_done)
    );

    `PDRW_ASSERT_NOW(a_idle_no_word, clk, rst_n, req_ready, !wr_valid, "word pending while idle")
    `PDRW_ASSERT_NOW(a_div_done_state, clk, rst_n, div_st.done, state_reg == ST_DIV, "divider done outside DIV")
    `PDRW_ASSERT_NEXT(a_last_to_idle, clk, rst_n, seq_done, req_ready, "no return to idle after last word")
    `PDRW_ASSERT_NOW(a_div_quiet, clk, rst_n, state_reg == ST_IDLE || state_reg == ST_SEND, !div_st.busy, "divider busy out of order")

endmodule

// ===== verif/tb_pwm_duty_to_register_writer.sv =====
module tb_pwm_duty_to_register_writer;

    localparam logic [1:0] KIND_BAD    = 2'd3;   // undefined request kind, dropped
    localparam logic [1:0] K_CFG       = pdrw_pkg::KIND_CONFIG;
    localparam logic [1:0] K_EN        = pdrw_pkg::KIND_ENABLE;
    localparam logic [1:0] K_DIS       = pdrw_pkg::KIND_DISABLE;
    localparam logic [pdrw_pkg::VAL_W-1:0] VMAX = {pdrw_pkg::VAL_W{1'b1}};
    localparam int         HOLD_CYCLES = 300;
    localparam int         SETTLE      = 40;
    localparam int         WATCHDOG    = 3000;
    localparam int         PHASE_ITEMS = 72;

    // words that can be typed in directly for channel 0
    localparam pdrw_pkg::wr_t NO_WR  = '0;
    localparam pdrw_pkg::wr_t W_OFF  = '{pdrw_pkg::ADDR_OFF_H, pdrw_pkg::FULL_FLAG, 1'b1};
    localparam pdrw_pkg::wr_t W_ON0  = '{pdrw_pkg::ADDR_ON_H, pdrw_pkg::FULL_FLAG, 1'b0};
    localparam pdrw_pkg::wr_t W_ON1  = '{pdrw_pkg::ADDR_OFF_H, 8'h00, 1'b1};
    localparam pdrw_pkg::wr_t W_HLF0 = '{pdrw_pkg::ADDR_ON_L, 8'h00, 1'b0};
    localparam pdrw_pkg::wr_t W_HLF1 = '{pdrw_pkg::ADDR_ON_H, 8'h00, 1'b0};
    localparam pdrw_pkg::wr_t W_HLF2 = '{pdrw_pkg::ADDR_OFF_L, 8'h00, 1'b0};
    localparam pdrw_pkg::wr_t W_HLF3 = '{pdrw_pkg::ADDR_OFF_H, 8'h08, 1'b1};

    typedef struct {
        pdrw_pkg::req_t rq;
        int             n_typed;   // -1: take the words from the predictor
        pdrw_pkg::wr_t  w [4];
    } row_t;

    logic                        clk;
    logic                        rst_n;
    logic                        cfg_we;
    logic [pdrw_pkg::CHAN_W-1:0] cfg_data;
    logic                        req_valid;
    logic                        req_ready;
    pdrw_pkg::req_t              req;
    logic                        wr_valid;
    logic                        wr_ready;
    pdrw_pkg::wr_t               wr;

    pwm_duty_to_register_writer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .wr_valid  (wr_valid),
        .wr_ready  (wr_ready),
        .wr        (wr)
    );

    // channel state as the block should hold it
    logic [pdrw_pkg::CHAN_W-1:0] chan_shadow;
    logic [1:0]                  en_state;
    logic [pdrw_pkg::VAL_W-1:0]  kept_duty;
    logic [pdrw_pkg::VAL_W-1:0]  kept_period;
    logic                        kept_pol;
    logic                        cfg_known;

    pdrw_pkg::wr_t  pending_writes [$];
    row_t           cur_row;
    pdrw_pkg::req_t last_cfg_sent;
    pdrw_pkg::wr_t  pred_w [4];
    pdrw_pkg::wr_t  got;
    int             n_pred;
    int             quiet_cycles;
    int             err_count;
    bit             calm;
    bit             hold_off;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int channel_writes(output pdrw_pkg::wr_t w [4]);
        logic [63:0] cnt;
        logic [63:0] on_pt;
        logic [63:0] off_pt;
        logic [6:0]  grp;
        w = '{NO_WR, NO_WR, NO_WR, NO_WR};
        grp = {1'b0, chan_shadow, 2'b00};
        if (en_state != pdrw_pkg::EN_OFF)
        begin
            if (kept_period == '0)
                cnt = 0;
            else if (kept_pol)
                cnt = (64'(kept_duty) * 64'(pdrw_pkg::COUNT_STEPS_DEF)) / 64'(kept_period);
            else if (kept_duty > kept_period)
                cnt = 0;
            else
                cnt = (64'(kept_period - kept_duty) * 64'(pdrw_pkg::COUNT_STEPS_DEF))
                      / 64'(kept_period);
        end
        else
        begin
            cnt = kept_pol ? 64'd0 : 64'(pdrw_pkg::COUNT_STEPS_DEF);
        end

        if (cnt == 0)
        begin
            w[0] = '{pdrw_pkg::ADDR_OFF_H + grp, pdrw_pkg::FULL_FLAG, 1'b1};
            return 1;
        end
        if (cnt >= pdrw_pkg::COUNT_STEPS_DEF)
        begin
            w[0] = '{pdrw_pkg::ADDR_ON_H + grp, pdrw_pkg::FULL_FLAG, 1'b0};
            w[1] = '{pdrw_pkg::ADDR_OFF_H + grp, 8'h00, 1'b1};
            return 2;
        end
        // on edge staggered per channel, off edge wraps around the period
        on_pt  = (64'(chan_shadow)
                  * (pdrw_pkg::COUNT_STEPS_DEF / pdrw_pkg::CHANNEL_COUNT_DEF))
                 % pdrw_pkg::COUNT_STEPS_DEF;
        off_pt = (on_pt + cnt) % pdrw_pkg::COUNT_STEPS_DEF;
        w[0] = '{pdrw_pkg::ADDR_ON_L + grp, on_pt[7:0], 1'b0};
        w[1] = '{pdrw_pkg::ADDR_ON_H + grp, {4'h0, on_pt[11:8]}, 1'b0};
        w[2] = '{pdrw_pkg::ADDR_OFF_L + grp, off_pt[7:0], 1'b0};
        w[3] = '{pdrw_pkg::ADDR_OFF_H + grp, {4'h0, off_pt[11:8]}, 1'b1};
        return 4;
    endfunction

    function automatic int step_channel(input pdrw_pkg::req_t r,
                                        output pdrw_pkg::wr_t w [4]);
        logic [1:0] want;
        w = '{NO_WR, NO_WR, NO_WR, NO_WR};
        case (r.kind)
            pdrw_pkg::KIND_CONFIG:
            begin
                if (cfg_known && r.duty == kept_duty && r.period == kept_period &&
                    r.polarity == kept_pol)
                    return 0;
                kept_duty   = r.duty;
                kept_period = r.period;
                kept_pol    = r.polarity;
                cfg_known   = 1'b1;
                return channel_writes(w);
            end
            pdrw_pkg::KIND_ENABLE, pdrw_pkg::KIND_DISABLE:
            begin
                want = (r.kind == pdrw_pkg::KIND_ENABLE) ? pdrw_pkg::EN_ON : pdrw_pkg::EN_OFF;
                if (en_state == want)
                    return 0;
                en_state = want;
                if (!cfg_known)
                    return 0;
                return channel_writes(w);
            end
            default:
                return 0;
        endcase
    endfunction

    function automatic row_t mk_row(input logic [1:0] k,
                                    input logic [pdrw_pkg::VAL_W-1:0] d,
                                    input logic [pdrw_pkg::VAL_W-1:0] p, input logic pol,
                                    input int n, input pdrw_pkg::wr_t a,
                                    input pdrw_pkg::wr_t b, input pdrw_pkg::wr_t c,
                                    input pdrw_pkg::wr_t e);
        row_t row;
        row.rq.kind     = k;
        row.rq.duty     = d;
        row.rq.period   = p;
        row.rq.polarity = pol;
        row.n_typed     = n;
        row.w[0] = a;
        row.w[1] = b;
        row.w[2] = c;
        row.w[3] = e;
        return row;
    endfunction

    function automatic pdrw_pkg::req_t random_request();
        pdrw_pkg::req_t r;
        int             pick;
        r.kind     = pdrw_pkg::KIND_CONFIG;
        r.duty     = pdrw_pkg::VAL_W'($urandom());
        r.period   = pdrw_pkg::VAL_W'($urandom());
        r.polarity = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 99);
        if (pick < 40)
        begin
            r.period = pdrw_pkg::VAL_W'($urandom_range(1, 5000));
            r.duty   = pdrw_pkg::VAL_W'($urandom_range(0,
                                         int'(r.period) + int'(r.period) / 4));
        end
        else if (pick < 50)
        begin
            // full-range duty and period as drawn
        end
        else if (pick < 58)
        begin
            r = last_cfg_sent;
        end
        else if (pick < 63)
        begin
            r.period   = pdrw_pkg::VAL_W'($urandom_range(1, 3000));
            r.duty     = r.period + pdrw_pkg::VAL_W'($urandom_range(1, 500));
            r.polarity = 1'b0;
            if ($urandom_range(0, 1) == 0)
                r.period = '0;
        end
        else if (pick < 93)
        begin
            r.kind = ($urandom_range(0, 1) == 0) ? pdrw_pkg::KIND_ENABLE
                                                  : pdrw_pkg::KIND_DISABLE;
        end
        else
        begin
            r.kind = KIND_BAD;
        end
        if (r.kind == pdrw_pkg::KIND_CONFIG)
            last_cfg_sent = r;
        return r;
    endfunction

    function automatic int pick_gap();
        int p;
        if (calm)
            return 0;
        p = $urandom_range(0, 99);
        if (p < 55)
            return 0;
        if (p < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic offer_word(input row_t row);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req       <= row.rq;
        req_valid <= 1'b1;
        cur_row   = row;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
    endtask

    task automatic drain_writes();
        @(negedge clk);
        req_valid <= 1'b0;
        while (pending_writes.size() != 0)
            @(posedge clk);
        // a word that makes no writes may still be in flight
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_channel(input logic [pdrw_pkg::CHAN_W-1:0] ch);
        @(negedge clk);
        cfg_data    <= ch;
        cfg_we      <= 1'b1;
        chan_shadow = ch;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // write sink: random stalls, calm stretches, one long hold-off on request
    initial
    begin : sink
        int stall;
        int p;
        stall    = 0;
        wr_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                wr_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_off = 1'b0;
            end
            else if (calm)
            begin
                wr_ready <= 1'b1;
            end
            else if (stall > 0)
            begin
                wr_ready <= 1'b0;
                stall--;
            end
            else
            begin
                p = $urandom_range(0, 99);
                if (p < 70)
                begin
                    wr_ready <= 1'b1;
                end
                else
                begin
                    wr_ready <= 1'b0;
                    stall = (p < 95) ? $urandom_range(0, 3) : $urandom_range(15, 50);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && req_ready)
            begin
                n_pred = step_channel(req, pred_w);
                if (cur_row.n_typed >= 0)
                begin
                    for (int i = 0; i < cur_row.n_typed; i++)
                        pending_writes.push_back(cur_row.w[i]);
                end
                else
                begin
                    for (int i = 0; i < n_pred; i++)
                        pending_writes.push_back(pred_w[i]);
                end
            end
            if (wr_valid && wr_ready)
            begin
                if (pending_writes.size() == 0)
                begin
                    $error("unexpected write word: reg_address=%0d reg_data=%0h last=%0b",
                           wr.reg_address, wr.reg_data, wr.last);
                    err_count++;
                end
                else
                begin
                    got = pending_writes.pop_front();
                    if (wr.reg_address !== got.reg_address)
                    begin
                        $error("reg_address: expected %0d, got %0d",
                               got.reg_address, wr.reg_address);
                        err_count++;
                    end
                    if (wr.reg_data !== got.reg_data)
                    begin
                        $error("reg_data: expected %0h, got %0h", got.reg_data, wr.reg_data);
                        err_count++;
                    end
                    if (wr.last !== got.last)
                    begin
                        $error("last: expected %0b, got %0b", got.last, wr.last);
                        err_count++;
                    end
                end
            end
            if ((req_valid && req_ready) || (wr_valid && wr_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        row_t                        script [$];
        row_t                        row;
        logic [pdrw_pkg::CHAN_W-1:0] ch;

        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_data     = '0;
        req_valid    = 1'b0;
        req          = '0;
        calm         = 1'b0;
        hold_off     = 1'b0;
        quiet_cycles = 0;
        err_count    = 0;
        chan_shadow  = '0;
        en_state     = pdrw_pkg::EN_UNKNOWN;
        kept_duty    = '0;
        kept_period  = '0;
        kept_pol     = 1'b0;
        cfg_known    = 1'b0;
        last_cfg_sent = '0;
        cur_row      = mk_row(KIND_BAD, '0, '0, 1'b0, 0, NO_WR, NO_WR, NO_WR, NO_WR);

        // enable/disable before any configure make no writes
        script.push_back(mk_row(K_EN, 0, 0, 0, 0, NO_WR, NO_WR, NO_WR, NO_WR));
        script.push_back(mk_row(K_DIS, 0, 0, 0, 0, NO_WR, NO_WR, NO_WR, NO_WR));
        script.push_back(mk_row(KIND_BAD, 77, 9, 1, 0, NO_WR, NO_WR, NO_WR, NO_WR));
        // first configure while disabled
        script.push_back(mk_row(K_CFG, 0, 100, 1, 1, W_OFF, NO_WR, NO_WR, NO_WR));
        script.push_back(mk_row(K_EN, 0, 0, 0, 1, W_OFF, NO_WR, NO_WR, NO_WR));
        script.push_back(mk_row(K_EN, 0, 0, 0, 0, NO_WR, NO_WR, NO_WR, NO_WR));
        script.push_back(mk_row(K_CFG, 0, 100, 1, 0, NO_WR, NO_WR, NO_WR, NO_WR));
        script.push_back(mk_row(K_CFG, 100, 100, 1, 2, W_ON0, W_ON1, NO_WR, NO_WR));
        script.push_back(mk_row(K_CFG, VMAX, 1, 1, 2, W_ON0, W_ON1, NO_WR, NO_WR));
        script.push_back(mk_row(K_CFG, VMAX, VMAX, 1, 2, W_ON0, W_ON1, NO_WR, NO_WR));
        script.push_back(mk_row(K_CFG, 5, 0, 1, 1, W_OFF, NO_WR, NO_WR, NO_WR));
        script.push_back(mk_row(K_CFG, 50, 100, 1, 4, W_HLF0, W_HLF1, W_HLF2, W_HLF3));
        script.push_back(mk_row(K_CFG, 50, 100, 0, -1, NO_WR, NO_WR, NO_WR, NO_WR));
        script.push_back(mk_row(K_CFG, 200, 100, 0, 1, W_OFF, NO_WR, NO_WR, NO_WR));
        script.push_back(mk_row(K_CFG, 0, 100, 0, 2, W_ON0, W_ON1, NO_WR, NO_WR));
        script.push_back(mk_row(K_DIS, 0, 0, 0, 2, W_ON0, W_ON1, NO_WR, NO_WR));
        script.push_back(mk_row(K_CFG, 1, VMAX, 1, 1, W_OFF, NO_WR, NO_WR, NO_WR));
        script.push_back(mk_row(K_EN, VMAX, VMAX, 1, -1, NO_WR, NO_WR, NO_WR, NO_WR));
        script.push_back(mk_row(K_CFG, 1, 4096, 1, -1, NO_WR, NO_WR, NO_WR, NO_WR));
        script.push_back(mk_row(K_CFG, 4095, 4096, 1, -1, NO_WR, NO_WR, NO_WR, NO_WR));
        script.push_back(mk_row(K_CFG, VMAX - 1, VMAX, 0, -1, NO_WR, NO_WR, NO_WR, NO_WR));
        script.push_back(mk_row(K_CFG, 0, 0, 0, -1, NO_WR, NO_WR, NO_WR, NO_WR));
        script.push_back(mk_row(KIND_BAD, VMAX, VMAX, 1, 0, NO_WR, NO_WR, NO_WR, NO_WR));
        script.push_back(mk_row(K_CFG, VMAX, VMAX, 0, -1, NO_WR, NO_WR, NO_WR, NO_WR));

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_channel('0);
        foreach (script[i])
            offer_word(script[i]);
        drain_writes();

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:       ch = {pdrw_pkg::CHAN_W{1'b1}};
                2:       ch = '0;
                default: ch = pdrw_pkg::CHAN_W'($urandom_range(1, 14));
            endcase
            write_channel(ch);
            // sink holds off while requests keep coming; the block must back up
            if (ph == 1)
                hold_off = 1'b1;
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                calm = ((k % 40) < 8);
                row = mk_row(KIND_BAD, '0, '0, 1'b0, -1, NO_WR, NO_WR, NO_WR, NO_WR);
                row.rq = random_request();
                offer_word(row);
            end
            calm = 1'b0;
            drain_writes();
        end

        if (err_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+src
src/pdrw_pkg.sv
src/pdrw_div.sv
src/pdrw_wr.sv
src/pwm_duty_to_register_writer.sv
verif/tb_pwm_duty_to_register_writer.sv
